### hw/rtl/heq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// heq_pkg
// Shared types and constants of the histogram equalizer: opcode, controller
// states and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package heq_pkg;

  localparam int NumBins  = 256;
  localparam int BinW     = 8;
  localparam int PixCntW  = 17;

  localparam logic [BinW-1:0]    LevelMax    = 8'd255;
  localparam logic [PixCntW-1:0] PixCntReset = 17'd16384;

  typedef enum logic {
    CMD_ACC = 1'b0,
    CMD_MAP = 1'b1
  } heq_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_MAP,
    ST_BLD_RD,
    ST_BLD_ADD,
    ST_BLD_DIV
  } heq_state_e;

  typedef struct packed {
    logic take_in;
    logic acc_update;
    logic bld_rd;
    logic bld_add;
    logic bld_step;
    logic bld_store;
    logic bld_finish;
    logic out_load;
  } heq_cmd_t;

  typedef struct packed {
    logic frame_full;
    logic div_more;
    logic last_bin;
    logic out_free;
  } heq_status_t;

endpackage
`default_nettype wire

### hw/rtl/heq_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// heq_ram
// Generic single-write, single-read RAM with registered read data. Read data
// holds while no read is issued.
// ----------------------------------------------------------------------------
module heq_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

### hw/rtl/heq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// heq_ctrl
// Controller: sequences accumulate and map beats and the table build walk
// over the 256 bins (read, add, repeated subtract, store).
// ----------------------------------------------------------------------------
module heq_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  input  wire logic                 cmd_i,
  output logic                      in_ready_o,
  input  wire heq_pkg::heq_status_t status_i,
  output heq_pkg::heq_cmd_t         cmd_o
);

  heq_pkg::heq_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= heq_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      heq_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take_in = 1'b1;
          state_d = (cmd_i == heq_pkg::CMD_MAP) ? heq_pkg::ST_MAP : heq_pkg::ST_ACC;
        end
      end
      heq_pkg::ST_ACC: begin
        cmd_o.acc_update = 1'b1;
        state_d = status_i.frame_full ? heq_pkg::ST_BLD_RD : heq_pkg::ST_IDLE;
      end
      heq_pkg::ST_MAP: begin
        // hold the result load until the output register frees up
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = heq_pkg::ST_IDLE;
        end
      end
      heq_pkg::ST_BLD_RD: begin
        cmd_o.bld_rd = 1'b1;
        state_d = heq_pkg::ST_BLD_ADD;
      end
      heq_pkg::ST_BLD_ADD: begin
        cmd_o.bld_add = 1'b1;
        state_d = heq_pkg::ST_BLD_DIV;
      end
      heq_pkg::ST_BLD_DIV: begin
        if (status_i.div_more) begin
          cmd_o.bld_step = 1'b1;
        end else begin
          cmd_o.bld_store = 1'b1;
          if (status_i.last_bin) begin
            cmd_o.bld_finish = 1'b1;
            state_d = heq_pkg::ST_IDLE;
          end else begin
            state_d = heq_pkg::ST_BLD_ADD;
          end
        end
      end
      default: begin
        state_d = heq_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

### hw/rtl/heq_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// heq_datapath
// Histogram and level table memories, frame counter, the running
// remainder/level pair of the table build, and the result register.
// ----------------------------------------------------------------------------
module heq_datapath #(
  parameter int unsigned MAX_PIXELS = 65536
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_valid_i,
  input  wire logic [heq_pkg::PixCntW-1:0]         cfg_pixel_count_i,
  input  wire logic                                cmd_i,
  input  wire logic [heq_pkg::BinW-1:0]            pixel_i,
  input  wire logic                                out_ready_i,
  output logic                                     out_valid_o,
  output logic      [heq_pkg::BinW-1:0]            mapped_pixel_o,
  output logic                                     table_ready_o,
  input  wire heq_pkg::heq_cmd_t                   ctrl_cmd_i,
  output heq_pkg::heq_status_t                     status_o
);

  localparam int unsigned CfgMax = (1 << heq_pkg::PixCntW) - 1;
  localparam int unsigned EffMax = (MAX_PIXELS < CfgMax) ? MAX_PIXELS : CfgMax;
  localparam int CntW = $clog2(EffMax + 1);
  localparam int BinW = heq_pkg::BinW;
  localparam int RemW = CntW + BinW;

  logic [heq_pkg::PixCntW-1:0] cfg_q;
  logic [CntW-1:0]             acc_q, acc_d;
  logic [heq_pkg::NumBins-1:0] vld_q, vld_d;
  logic                        built_q, built_d;
  logic [BinW-1:0]             idx_q, idx_d;
  logic [RemW-1:0]             rem_q, rem_d;
  logic [BinW-1:0]             lvl_q, lvl_d;
  logic [BinW-1:0]             pix_q;
  logic                        out_valid_q, out_valid_d;
  logic [BinW-1:0]             mapped_q;
  logic                        ready_flag_q;

  logic [31:0]     pc_ext, n_wide;
  logic [CntW-1:0] frame_n;
  logic [CntW:0]   acc_inc;
  logic [CntW-1:0] bin_rdata, bin_acc, bin_bld, bin_new;
  logic [RemW-1:0] c255;
  logic [BinW-1:0] tbl_rdata;
  logic            bin_re, tbl_re;
  logic [BinW-1:0] bin_raddr;

  // effective frame size: zero acts as one, clamp at the maximum
  assign pc_ext = 32'(cfg_q);
  always_comb begin
    if (cfg_q == '0) begin
      n_wide = 32'd1;
    end else if (pc_ext > EffMax) begin
      n_wide = 32'(EffMax);
    end else begin
      n_wide = pc_ext;
    end
  end
  assign frame_n = n_wide[CntW-1:0];

  assign acc_inc = {1'b0, acc_q} + {{CntW{1'b0}}, 1'b1};

  // a bin without its valid bit reads as zero
  assign bin_acc = vld_q[pix_q] ? bin_rdata : '0;
  assign bin_bld = vld_q[idx_q] ? bin_rdata : '0;
  assign bin_new = bin_acc + CntW'(1);
  assign c255    = {bin_bld, {BinW{1'b0}}} - {{BinW{1'b0}}, bin_bld};

  assign status_o.frame_full = acc_inc >= {1'b0, frame_n};
  assign status_o.div_more   = (lvl_q != heq_pkg::LevelMax) &&
                               (rem_q >= {{BinW{1'b0}}, frame_n});
  assign status_o.last_bin   = (idx_q == BinW'(heq_pkg::NumBins - 1));
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  // memory read ports
  assign bin_re = (ctrl_cmd_i.take_in && cmd_i == heq_pkg::CMD_ACC) ||
                  ctrl_cmd_i.bld_rd || ctrl_cmd_i.bld_store;
  assign tbl_re = ctrl_cmd_i.take_in && cmd_i == heq_pkg::CMD_MAP;
  always_comb begin
    if (ctrl_cmd_i.take_in) begin
      bin_raddr = pixel_i;
    end else if (ctrl_cmd_i.bld_store) begin
      bin_raddr = idx_q + BinW'(1);
    end else begin
      bin_raddr = idx_q;
    end
  end

  heq_ram #(
    .Width (CntW),
    .Depth (heq_pkg::NumBins)
  ) u_bin_ram (
    .clk_i   (clk_i),
    .we_i    (ctrl_cmd_i.acc_update),
    .waddr_i (pix_q),
    .wdata_i (bin_new),
    .re_i    (bin_re),
    .raddr_i (bin_raddr),
    .rdata_o (bin_rdata)
  );

  heq_ram #(
    .Width (BinW),
    .Depth (heq_pkg::NumBins)
  ) u_tbl_ram (
    .clk_i   (clk_i),
    .we_i    (ctrl_cmd_i.bld_store),
    .waddr_i (idx_q),
    .wdata_i (lvl_q),
    .re_i    (tbl_re),
    .raddr_i (pixel_i),
    .rdata_o (tbl_rdata)
  );

  always_comb begin
    acc_d       = acc_q;
    vld_d       = vld_q;
    built_d     = built_q;
    idx_d       = idx_q;
    rem_d       = rem_q;
    lvl_d       = lvl_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (ctrl_cmd_i.acc_update) begin
      acc_d        = acc_inc[CntW-1:0];
      vld_d[pix_q] = 1'b1;
    end
    if (ctrl_cmd_i.bld_add) begin
      rem_d = rem_q + c255;
    end
    if (ctrl_cmd_i.bld_step) begin
      rem_d = rem_q - {{BinW{1'b0}}, frame_n};
      lvl_d = lvl_q + BinW'(1);
    end
    if (ctrl_cmd_i.bld_store) begin
      idx_d = idx_q + BinW'(1);
    end
    // drop the histogram and restart the build registers
    if (ctrl_cmd_i.bld_finish) begin
      acc_d   = '0;
      vld_d   = '0;
      built_d = 1'b1;
      idx_d   = '0;
      rem_d   = '0;
      lvl_d   = '0;
    end
    if (ctrl_cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= heq_pkg::PixCntReset;
      acc_q       <= '0;
      vld_q       <= '0;
      built_q     <= 1'b0;
      idx_q       <= '0;
      rem_q       <= '0;
      lvl_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        cfg_q <= cfg_pixel_count_i;
      end
      acc_q       <= acc_d;
      vld_q       <= vld_d;
      built_q     <= built_d;
      idx_q       <= idx_d;
      rem_q       <= rem_d;
      lvl_q       <= lvl_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_cmd_i.take_in) begin
      pix_q <= pixel_i;
    end
    if (ctrl_cmd_i.out_load) begin
      mapped_q     <= built_q ? tbl_rdata : '0;
      ready_flag_q <= built_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign mapped_pixel_o = mapped_q;
  assign table_ready_o  = ready_flag_q;

`ifndef SYNTHESIS
  a_finish_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_cmd_i.bld_finish |=> built_q && (acc_q == '0) && (vld_q == '0))
    else $error("histogram not cleared after table build");

  a_store_settled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_cmd_i.bld_store |-> (lvl_q == heq_pkg::LevelMax) ||
                             (rem_q < {{BinW{1'b0}}, frame_n}))
    else $error("level stored before the remainder settled");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_cmd_i.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten while holding a beat");
`endif

endmodule
`default_nettype wire

### hw/rtl/histogram_equalizer_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// histogram_equalizer_top
// Two-pass global histogram equalizer for 8-bit grayscale frames.
// ----------------------------------------------------------------------------
// Input beats (cmd_i, pixel_i) come on a valid/ready channel. An accumulate
// beat adds the pixel to the histogram; a map beat returns the level table
// entry on the output channel (mapped_pixel_o, table_ready_o).
// cfg_pixel_count_i sets the frame size; write it only while the block idles.
// An accumulate beat reads its bin from the bin RAM, then writes it back. A map
// beat reads the level table entry, then loads it into the result register once
// that register is free.
// When a frame completes, the table build walks the 256 bins on one bin RAM
// read port: per bin an add and a store, plus one subtract per level step, at
// most 255 steps in all; no input is accepted meanwhile. The output register
// frees the input side: a new beat is taken while a result waits; a further
// map beat stalls until the receiver takes it.
// Reset clears the histogram (per-bin valid bits), the frame counter and the
// built flag; until the first build every map returns zero, table_ready_o low.
// ----------------------------------------------------------------------------
module histogram_equalizer_top #(
  parameter int unsigned MAX_PIXELS = 65536
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [heq_pkg::PixCntW-1:0] cfg_pixel_count_i,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic                        cmd_i,
  input  wire logic [heq_pkg::BinW-1:0]    pixel_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic      [heq_pkg::BinW-1:0]    mapped_pixel_o,
  output logic                             table_ready_o
);

  heq_pkg::heq_cmd_t    ctrl_cmd;
  heq_pkg::heq_status_t dp_status;

  assign cfg_ready_o = 1'b1;

  heq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .cmd_i      (cmd_i),
    .in_ready_o (in_ready_o),
    .status_i   (dp_status),
    .cmd_o      (ctrl_cmd)
  );

  heq_datapath #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_pixel_count_i (cfg_pixel_count_i),
    .cmd_i             (cmd_i),
    .pixel_i           (pixel_i),
    .out_ready_i       (out_ready_i),
    .out_valid_o       (out_valid_o),
    .mapped_pixel_o    (mapped_pixel_o),
    .table_ready_o     (table_ready_o),
    .ctrl_cmd_i        (ctrl_cmd),
    .status_o          (dp_status)
  );

endmodule
`default_nettype wire

### bench/histogram_equalizer_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// histogram_equalizer_top_test
// Self-checking bench for the histogram equalizer. A directed table covers
// the frame size extremes, map before the first build, saturated levels and
// frame size lowered mid-frame. Random frames with skewed pixel windows
// follow. Each map beat, with random idling on both sides, is checked against
// its pinned level or a predictor of histogram, level table and frame counter.
// ----------------------------------------------------------------------------
module histogram_equalizer_top_test;

  localparam int MaxPixels   = 65536;
  localparam int BuildCycles = 800;   // worst case table build plus margin
  localparam int LongHold    = 400;
  localparam int RandItems   = 1250;
  localparam int NumRows     = 25;

  typedef logic [heq_pkg::BinW-1:0]    pix_t;
  typedef logic [heq_pkg::PixCntW-1:0] frame_size_t;

  typedef enum logic {
    ROW_BEAT,
    ROW_FRAME_SIZE
  } row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    heq_pkg::heq_op_e  op;
    pix_t              pix;
    frame_size_t       size;
    logic              pinned;
    pix_t              want_level;
    logic              want_ready;
  } plan_row_t;

  typedef struct packed {
    pix_t level;
    logic ready;
  } heq_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  frame_size_t cfg_pixel_count_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        cmd_i = 1'b0;
  pix_t        pixel_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  pix_t        mapped_pixel_o;
  logic        table_ready_o;

  // expectation typed into the table, travels with the beat
  logic        pin_en = 1'b0;
  pix_t        pin_level = '0;
  logic        pin_ready = 1'b0;

  int src_idle_pct  = 28;
  int sink_idle_pct = 56;
  bit hold_go   = 1'b0;
  bit hold_used = 1'b0;
  int hold_left = 0;
  int mismatches = 0;

  // predictor state
  frame_size_t        frame_cfg;
  int unsigned        hist [heq_pkg::NumBins];
  pix_t               lut [heq_pkg::NumBins];
  int unsigned        frame_fill;
  logic               lut_built;
  heq_result_t        pending_levels [$];

  bit          beat_has_level;
  heq_result_t beat_level;
  heq_result_t want;

  plan_row_t plan [NumRows] = '{
    '{ROW_BEAT,       heq_pkg::CMD_MAP, 8'd0,   17'd0,      1'b1, 8'd0,   1'b0},
    '{ROW_BEAT,       heq_pkg::CMD_MAP, 8'd255, 17'd0,      1'b1, 8'd0,   1'b0},
    '{ROW_FRAME_SIZE, heq_pkg::CMD_ACC, 8'd0,   17'd0,      1'b0, 8'd0,   1'b0},
    '{ROW_BEAT,       heq_pkg::CMD_ACC, 8'd0,   17'd0,      1'b0, 8'd0,   1'b0},
    '{ROW_BEAT,       heq_pkg::CMD_MAP, 8'd0,   17'd0,      1'b1, 8'd255, 1'b1},
    '{ROW_BEAT,       heq_pkg::CMD_MAP, 8'd255, 17'd0,      1'b1, 8'd255, 1'b1},
    '{ROW_FRAME_SIZE, heq_pkg::CMD_ACC, 8'd0,   17'd4,      1'b0, 8'd0,   1'b0},
    '{ROW_BEAT,       heq_pkg::CMD_ACC, 8'd255, 17'd0,      1'b0, 8'd0,   1'b0},
    '{ROW_BEAT,       heq_pkg::CMD_ACC, 8'd0,   17'd0,      1'b0, 8'd0,   1'b0},
    '{ROW_BEAT,       heq_pkg::CMD_ACC, 8'd128, 17'd0,      1'b0, 8'd0,   1'b0},
    '{ROW_BEAT,       heq_pkg::CMD_ACC, 8'd128, 17'd0,      1'b0, 8'd0,   1'b0},
    '{ROW_BEAT,       heq_pkg::CMD_MAP, 8'd127, 17'd0,      1'b0, 8'd0,   1'b0},
    '{ROW_BEAT,       heq_pkg::CMD_MAP, 8'd128, 17'd0,      1'b0, 8'd0,   1'b0},
    '{ROW_BEAT,       heq_pkg::CMD_MAP, 8'd255, 17'd0,      1'b1, 8'd255, 1'b1},
    '{ROW_FRAME_SIZE, heq_pkg::CMD_ACC, 8'd0,   17'd131071, 1'b0, 8'd0,   1'b0},
    '{ROW_BEAT,       heq_pkg::CMD_ACC, 8'd7,   17'd0,      1'b0, 8'd0,   1'b0},
    '{ROW_BEAT,       heq_pkg::CMD_ACC, 8'd200, 17'd0,      1'b0, 8'd0,   1'b0},
    '{ROW_BEAT,       heq_pkg::CMD_ACC, 8'd7,   17'd0,      1'b0, 8'd0,   1'b0},
    '{ROW_FRAME_SIZE, heq_pkg::CMD_ACC, 8'd0,   17'd65536,  1'b0, 8'd0,   1'b0},
    '{ROW_BEAT,       heq_pkg::CMD_MAP, 8'd0,   17'd0,      1'b0, 8'd0,   1'b0},
    // lower the frame size below the pixels already counted
    '{ROW_FRAME_SIZE, heq_pkg::CMD_ACC, 8'd0,   17'd2,      1'b0, 8'd0,   1'b0},
    '{ROW_BEAT,       heq_pkg::CMD_ACC, 8'd100, 17'd0,      1'b0, 8'd0,   1'b0},
    '{ROW_BEAT,       heq_pkg::CMD_MAP, 8'd6,   17'd0,      1'b1, 8'd0,   1'b1},
    '{ROW_BEAT,       heq_pkg::CMD_MAP, 8'd255, 17'd0,      1'b1, 8'd255, 1'b1},
    '{ROW_BEAT,       heq_pkg::CMD_MAP, 8'd7,   17'd0,      1'b0, 8'd0,   1'b0}
  };

  histogram_equalizer_top #(
    .MAX_PIXELS(MaxPixels)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_pixel_count_i(cfg_pixel_count_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .cmd_i            (cmd_i),
    .pixel_i          (pixel_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .mapped_pixel_o   (mapped_pixel_o),
    .table_ready_o    (table_ready_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #15_000_000;
    $display("histogram_equalizer_top_test: FAIL");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int exp_val);
    if (mismatches < 100)
      $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, exp_val);
    mismatches++;
  endtask

  // Advance the histogram by one beat; a map beat yields its level.
  function automatic void equalize_beat(input heq_pkg::heq_op_e op, input pix_t pix,
                                        output bit has_level, output heq_result_t res);
    int unsigned     n;
    longint unsigned run;
    longint unsigned lvl;
    int              i;
    res = '0;
    has_level = 1'b0;
    if (op == heq_pkg::CMD_MAP) begin
      res.level = lut[pix];
      res.ready = lut_built;
      has_level = 1'b1;
      return;
    end
    hist[pix]++;
    frame_fill++;
    n = 32'(frame_cfg);
    if (n == 0) n = 1;
    if (n > 32'(MaxPixels)) n = 32'(MaxPixels);
    if (frame_fill >= n) begin
      run = 0;
      for (i = 0; i < heq_pkg::NumBins; i++) begin
        run += 64'(hist[i]);
        lvl = run * 64'(heq_pkg::LevelMax) / 64'(n);
        lut[i] = (lvl > 64'(heq_pkg::LevelMax)) ? heq_pkg::LevelMax : lvl[heq_pkg::BinW-1:0];
        hist[i] = 0;
      end
      frame_fill = 0;
      lut_built = 1'b1;
    end
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      frame_cfg = heq_pkg::PixCntReset;
      for (int i = 0; i < heq_pkg::NumBins; i++) begin
        hist[i] = 0;
        lut[i] = '0;
      end
      frame_fill = 0;
      lut_built = 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) frame_cfg = cfg_pixel_count_i;
      if (in_valid_i && in_ready_o) begin
        equalize_beat(heq_pkg::heq_op_e'(cmd_i), pixel_i, beat_has_level, beat_level);
        if (beat_has_level)
          pending_levels.push_back(pin_en ? heq_result_t'({pin_level, pin_ready}) : beat_level);
      end
      if (out_valid_o && out_ready_i) begin
        if (pending_levels.size() == 0) begin
          report_mismatch("result beat with nothing pending", int'(mapped_pixel_o), -1);
        end else begin
          want = pending_levels.pop_front();
          if (mapped_pixel_o !== want.level)
            report_mismatch("mapped_pixel", int'(mapped_pixel_o), int'(want.level));
          if (table_ready_o !== want.ready)
            report_mismatch("table_ready", int'(table_ready_o), int'(want.ready));
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold to back the block up.
  always @(negedge clk_i) begin
    if (hold_go && !hold_used) begin
      hold_used = 1'b1;
      hold_left = LongHold;
    end
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left--;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  task automatic push_beat(input heq_pkg::heq_op_e op, input pix_t pix,
                           input logic pinned, input pix_t lvl,
                           input logic rdy);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    cmd_i      = op;
    pixel_i    = pix;
    pin_en     = pinned;
    pin_level  = lvl;
    pin_ready  = rdy;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Drain, let any table build finish, then write the frame size.
  task automatic write_frame_size(input frame_size_t size);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_levels.size() != 0) @(negedge clk_i);
    repeat (BuildCycles) @(negedge clk_i);
    cfg_pixel_count_i = size;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  initial begin : stimulus
    int sent;
    int phase;
    int pick;
    int fsize;
    int eff;
    int accs;
    int lo;
    int hi;
    int maps;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    for (int r = 0; r < NumRows; r++) begin
      if (plan[r].kind == ROW_FRAME_SIZE)
        write_frame_size(plan[r].size);
      else
        push_beat(plan[r].op, plan[r].pix, plan[r].pinned, plan[r].want_level,
                  plan[r].want_ready);
    end

    sent = 0;
    phase = 0;
    while (sent < RandItems) begin
      if (sent < RandItems / 3) begin
        src_idle_pct = 28;
        sink_idle_pct = 56;
      end else if (sent < 2 * RandItems / 3) begin
        src_idle_pct = 56;
        sink_idle_pct = 28;
      end else begin
        src_idle_pct = 0;
        sink_idle_pct = 0;
      end

      pick = $urandom_range(0, 99);
      if (pick < 4)       fsize = 0;
      else if (pick < 12) fsize = $urandom_range(1, 4);
      else if (pick < 82) fsize = $urandom_range(5, 48);
      else if (pick < 92) fsize = $urandom_range(49, 200);
      else if (pick < 96) fsize = MaxPixels;
      else                fsize = $urandom_range(MaxPixels + 1, (1 << heq_pkg::PixCntW) - 1);
      write_frame_size(frame_size_t'(fsize));

      eff = (fsize == 0) ? 1 : ((fsize > MaxPixels) ? MaxPixels : fsize);
      // partial and overlong frames carry counts into the next frame size
      accs = (eff <= 200) ? $urandom_range(eff / 2, eff + eff / 2) : $urandom_range(5, 40);
      lo = $urandom_range(0, 255);
      hi = lo + $urandom_range(0, 255);
      if (hi > 255) hi = 255;

      repeat (accs) begin
        if ($urandom_range(0, 4) == 0) begin
          push_beat(heq_pkg::CMD_MAP, pix_t'($urandom_range(0, 255)), 1'b0, '0, 1'b0);
          sent++;
        end
        push_beat(heq_pkg::CMD_ACC, pix_t'($urandom_range(lo, hi)), 1'b0, '0, 1'b0);
        sent++;
      end

      if (phase == 3) hold_go = 1'b1;
      maps = $urandom_range(8, 24);
      repeat (maps) begin
        if ($urandom_range(0, 1) == 0)
          push_beat(heq_pkg::CMD_MAP, pix_t'($urandom_range(lo, hi)), 1'b0, '0, 1'b0);
        else
          push_beat(heq_pkg::CMD_MAP, pix_t'($urandom_range(0, 255)), 1'b0, '0, 1'b0);
        sent++;
      end
      phase++;
    end

    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_levels.size() != 0) @(negedge clk_i);
    repeat (BuildCycles) @(negedge clk_i);
    if (mismatches == 0)
      $display("histogram_equalizer_top_test: PASS");
    else
      $display("histogram_equalizer_top_test: FAIL");
    $finish;
  end

endmodule

### files.f
hw/rtl/heq_pkg.sv
hw/rtl/heq_ram.sv
hw/rtl/heq_ctrl.sv
hw/rtl/heq_datapath.sv
hw/rtl/histogram_equalizer_top.sv
bench/histogram_equalizer_top_test.sv
